### rtl/fmrot_pkg.sv
package fmrot_pkg;

   // largest source dimension; coordinates at or beyond it produce no writes
   localparam int MAX_SRC_DIM = 4096;

   localparam int SRC_W    = 12;
   localparam int DST_W    = 13;
   localparam int LIM_W    = 14;
   localparam int TRIG_W   = 16;
   localparam int COL_W    = 8;
   localparam int FRAC_W   = 14;
   localparam int DELTA_W  = SRC_W + 1;
   localparam int PROD_W   = DELTA_W + TRIG_W;
   localparam int SUM_W    = 32;
   localparam int COORD_W  = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_TAPS = 5;

   localparam logic [LIM_W-1:0] CANVAS_LIMIT = LIM_W'(8192);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COS_Q14      = 4'd0,
      REG_SIN_Q14      = 4'd1,
      REG_SRC_CENTER_X = 4'd2,
      REG_SRC_CENTER_Y = 4'd3,
      REG_DST_CENTER_X = 4'd4,
      REG_DST_CENTER_Y = 4'd5,
      REG_DST_WIDTH    = 4'd6,
      REG_DST_HEIGHT   = 4'd7
   } reg_index_type;

   // splat tap order in the write mask
   typedef enum int {
      TAP_LEFT   = 0,
      TAP_CENTER = 1,
      TAP_RIGHT  = 2,
      TAP_ABOVE  = 3,
      TAP_BELOW  = 4
   } tap_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_q14;
      logic signed [TRIG_W-1:0] sin_q14;
      logic [SRC_W-1:0]         src_center_x;
      logic [SRC_W-1:0]         src_center_y;
      logic [DST_W-1:0]         dst_center_x;
      logic [DST_W-1:0]         dst_center_y;
      logic [LIM_W-1:0]         dst_width;
      logic [LIM_W-1:0]         dst_height;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] blue;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] alpha;
   } color_type;

   // rotation products handed from the multiply stage to the splat stage
   typedef struct packed {
      logic                     valid;
      logic                     drop;
      logic signed [PROD_W-1:0] dx_cos;
      logic signed [PROD_W-1:0] dy_sin;
      logic signed [PROD_W-1:0] dx_sin;
      logic signed [PROD_W-1:0] dy_cos;
      color_type                color;
   } prod_type;

endpackage

### rtl/fmrot_if.sv
interface fmrot_req_if;
   logic                          valid;
   logic                          ready;
   logic [fmrot_pkg::SRC_W-1:0]   src_x;
   logic [fmrot_pkg::SRC_W-1:0]   src_y;
   logic [fmrot_pkg::COL_W-1:0]   blue;
   logic [fmrot_pkg::COL_W-1:0]   green;
   logic [fmrot_pkg::COL_W-1:0]   red;
   logic [fmrot_pkg::COL_W-1:0]   alpha;

   modport source (output valid, src_x, src_y, blue, green, red, alpha, input ready);
   modport sink   (input valid, src_x, src_y, blue, green, red, alpha, output ready);
endinterface

interface fmrot_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fmrot_pkg::DST_W-1:0]   dst_x;
   logic [fmrot_pkg::DST_W-1:0]   dst_y;
   logic [fmrot_pkg::COL_W-1:0]   out_blue;
   logic [fmrot_pkg::COL_W-1:0]   out_green;
   logic [fmrot_pkg::COL_W-1:0]   out_red;
   logic [fmrot_pkg::COL_W-1:0]   out_alpha;
   logic                          last_write;

   modport source (output valid, dst_x, dst_y, out_blue, out_green, out_red, out_alpha,
                   last_write, input ready);
   modport sink   (input valid, dst_x, dst_y, out_blue, out_green, out_red, out_alpha,
                   last_write, output ready);
endinterface

interface fmrot_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fmrot_pkg::CSR_IDX_W-1:0]   index;
   logic [fmrot_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/fmrot_csr.sv
module fmrot_csr (
   input  logic              clock,
   input  logic              reset,
   fmrot_csr_if.sink         csr_if,
   output fmrot_pkg::cfg_type cfg
);

   fmrot_pkg::cfg_type cfg_ff, cfg_in;
   logic               wr_en;

   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_if.index)
            fmrot_pkg::REG_COS_Q14:      cfg_in.cos_q14 = csr_if.data;
            fmrot_pkg::REG_SIN_Q14:      cfg_in.sin_q14 = csr_if.data;
            fmrot_pkg::REG_SRC_CENTER_X:
               cfg_in.src_center_x = csr_if.data[fmrot_pkg::SRC_W-1:0];
            fmrot_pkg::REG_SRC_CENTER_Y:
               cfg_in.src_center_y = csr_if.data[fmrot_pkg::SRC_W-1:0];
            fmrot_pkg::REG_DST_CENTER_X:
               cfg_in.dst_center_x = csr_if.data[fmrot_pkg::DST_W-1:0];
            fmrot_pkg::REG_DST_CENTER_Y:
               cfg_in.dst_center_y = csr_if.data[fmrot_pkg::DST_W-1:0];
            fmrot_pkg::REG_DST_WIDTH:
               cfg_in.dst_width = csr_if.data[fmrot_pkg::LIM_W-1:0];
            fmrot_pkg::REG_DST_HEIGHT:
               cfg_in.dst_height = csr_if.data[fmrot_pkg::LIM_W-1:0];
            default: ;  // unknown index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_q14      <= fmrot_pkg::TRIG_W'(16384);
         cfg_ff.sin_q14      <= '0;
         cfg_ff.src_center_x <= '0;
         cfg_ff.src_center_y <= '0;
         cfg_ff.dst_center_x <= '0;
         cfg_ff.dst_center_y <= '0;
         cfg_ff.dst_width    <= fmrot_pkg::CANVAS_LIMIT;
         cfg_ff.dst_height   <= fmrot_pkg::CANVAS_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/fmrot_xform.sv
module fmrot_xform (
   input  logic               clock,
   input  logic               reset,
   fmrot_req_if.sink          req_if,
   input  fmrot_pkg::cfg_type cfg,
   input  logic               take,
   output fmrot_pkg::prod_type prod
);

   // input register
   logic                          a_valid_ff, a_valid_in;
   logic [fmrot_pkg::SRC_W-1:0]   a_src_x_ff, a_src_y_ff;
   fmrot_pkg::color_type          a_color_ff;

   // product register
   fmrot_pkg::prod_type           b_ff, b_in;

   logic                          a_adv, b_adv;
   logic signed [fmrot_pkg::DELTA_W-1:0] dx, dy;
   logic                          oversize;

   assign b_adv        = !b_ff.valid || take;
   assign a_adv        = !a_valid_ff || b_adv;
   assign req_if.ready = a_adv;
   assign a_valid_in   = a_adv ? req_if.valid : a_valid_ff;

   assign dx = $signed({1'b0, a_src_x_ff}) - $signed({1'b0, cfg.src_center_x});
   assign dy = $signed({1'b0, a_src_y_ff}) - $signed({1'b0, cfg.src_center_y});
   assign oversize = ({1'b0, a_src_x_ff} >= (fmrot_pkg::SRC_W+1)'(fmrot_pkg::MAX_SRC_DIM)) ||
                     ({1'b0, a_src_y_ff} >= (fmrot_pkg::SRC_W+1)'(fmrot_pkg::MAX_SRC_DIM));

   always_comb begin
      b_in = b_ff;
      if (b_adv) begin
         b_in.valid  = a_valid_ff;
         b_in.drop   = oversize;
         b_in.dx_cos = dx * cfg.cos_q14;
         b_in.dy_sin = dy * cfg.sin_q14;
         b_in.dx_sin = dx * cfg.sin_q14;
         b_in.dy_cos = dy * cfg.cos_q14;
         b_in.color  = a_color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_src_x_ff       <= req_if.src_x;
         a_src_y_ff       <= req_if.src_y;
         a_color_ff.blue  <= req_if.blue;
         a_color_ff.green <= req_if.green;
         a_color_ff.red   <= req_if.red;
         a_color_ff.alpha <= req_if.alpha;
      end
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_ff.valid <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_ff       <= b_in;
      end
   end

   assign prod = b_ff;

endmodule

### rtl/fmrot_splat.sv
module fmrot_splat (
   input  logic                clock,
   input  logic                reset,
   input  fmrot_pkg::cfg_type  cfg,
   input  fmrot_pkg::prod_type prod,
   output logic                take,
   fmrot_rsp_if.source         rsp_if
);

   localparam int CMP_W = fmrot_pkg::COORD_W + 1;

   logic signed [fmrot_pkg::SUM_W-1:0] sum_x, sum_y;
   logic                               neg;
   logic [fmrot_pkg::COORD_W-1:0]      nx, ny;
   logic [CMP_W-1:0]                   nxe, nye, lim_x, lim_y;
   logic [fmrot_pkg::LIM_W-1:0]        clip_w, clip_h;
   logic [fmrot_pkg::NUM_TAPS-1:0]     new_mask;

   // emitter register: remaining writes of the pixel in flight
   logic [fmrot_pkg::NUM_TAPS-1:0]     mask_ff, mask_in;
   logic [fmrot_pkg::DST_W-1:0]        nx_ff, ny_ff;
   fmrot_pkg::color_type               color_ff;

   logic [fmrot_pkg::NUM_TAPS-1:0]     sel;
   logic                               last, fire, load;

   // column and row sums at q.14
   assign sum_x = {{(fmrot_pkg::SUM_W-fmrot_pkg::PROD_W){prod.dx_cos[fmrot_pkg::PROD_W-1]}},
                   prod.dx_cos}
                - {{(fmrot_pkg::SUM_W-fmrot_pkg::PROD_W){prod.dy_sin[fmrot_pkg::PROD_W-1]}},
                   prod.dy_sin}
                + $signed({{(fmrot_pkg::SUM_W-fmrot_pkg::DST_W-fmrot_pkg::FRAC_W){1'b0}},
                   cfg.dst_center_x, {fmrot_pkg::FRAC_W{1'b0}}});
   assign sum_y = {{(fmrot_pkg::SUM_W-fmrot_pkg::PROD_W){prod.dx_sin[fmrot_pkg::PROD_W-1]}},
                   prod.dx_sin}
                + {{(fmrot_pkg::SUM_W-fmrot_pkg::PROD_W){prod.dy_cos[fmrot_pkg::PROD_W-1]}},
                   prod.dy_cos}
                + $signed({{(fmrot_pkg::SUM_W-fmrot_pkg::DST_W-fmrot_pkg::FRAC_W){1'b0}},
                   cfg.dst_center_y, {fmrot_pkg::FRAC_W{1'b0}}});

   // truncation toward zero: only sums at or below -1.0 give a negative target
   assign neg = (sum_x <= -32'sd16384) || (sum_y <= -32'sd16384);
   assign nx  = sum_x[fmrot_pkg::SUM_W-1] ? '0 :
                sum_x[fmrot_pkg::FRAC_W+fmrot_pkg::COORD_W-1:fmrot_pkg::FRAC_W];
   assign ny  = sum_y[fmrot_pkg::SUM_W-1] ? '0 :
                sum_y[fmrot_pkg::FRAC_W+fmrot_pkg::COORD_W-1:fmrot_pkg::FRAC_W];

   assign clip_w = (cfg.dst_width  > fmrot_pkg::CANVAS_LIMIT) ? fmrot_pkg::CANVAS_LIMIT
                                                              : cfg.dst_width;
   assign clip_h = (cfg.dst_height > fmrot_pkg::CANVAS_LIMIT) ? fmrot_pkg::CANVAS_LIMIT
                                                              : cfg.dst_height;
   assign nxe   = {1'b0, nx};
   assign nye   = {1'b0, ny};
   assign lim_x = CMP_W'(clip_w);
   assign lim_y = CMP_W'(clip_h);

   always_comb begin
      new_mask = '0;
      new_mask[fmrot_pkg::TAP_LEFT]   = (nx != '0) && ((nxe - CMP_W'(1)) < lim_x) &&
                                        (nye < lim_y);
      new_mask[fmrot_pkg::TAP_CENTER] = (nxe < lim_x) && (nye < lim_y);
      new_mask[fmrot_pkg::TAP_RIGHT]  = ((nxe + CMP_W'(1)) < lim_x) && (nye < lim_y);
      new_mask[fmrot_pkg::TAP_ABOVE]  = (ny != '0) && (nxe < lim_x) &&
                                        ((nye - CMP_W'(1)) < lim_y);
      new_mask[fmrot_pkg::TAP_BELOW]  = (nxe < lim_x) && ((nye + CMP_W'(1)) < lim_y);
      if (!prod.valid || prod.drop || neg) begin
         new_mask = '0;
      end
   end

   // lowest remaining tap goes out first
   assign sel  = mask_ff & (~mask_ff + fmrot_pkg::NUM_TAPS'(1));
   assign last = (mask_ff & ~sel) == '0;
   assign fire = rsp_if.valid && rsp_if.ready;
   assign take = (mask_ff == '0) || (rsp_if.ready && last);
   assign load = prod.valid && take;

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = new_mask;
      end else if (fire) begin
         mask_in = mask_ff & ~sel;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         nx_ff    <= nx[fmrot_pkg::DST_W-1:0];
         ny_ff    <= ny[fmrot_pkg::DST_W-1:0];
         color_ff <= prod.color;
      end
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_comb begin
      rsp_if.dst_x = nx_ff;
      rsp_if.dst_y = ny_ff;
      priority if (mask_ff[fmrot_pkg::TAP_LEFT]) begin
         rsp_if.dst_x = nx_ff - fmrot_pkg::DST_W'(1);
      end else if (mask_ff[fmrot_pkg::TAP_CENTER]) begin
         rsp_if.dst_x = nx_ff;
      end else if (mask_ff[fmrot_pkg::TAP_RIGHT]) begin
         rsp_if.dst_x = nx_ff + fmrot_pkg::DST_W'(1);
      end else if (mask_ff[fmrot_pkg::TAP_ABOVE]) begin
         rsp_if.dst_y = ny_ff - fmrot_pkg::DST_W'(1);
      end else if (mask_ff[fmrot_pkg::TAP_BELOW]) begin
         rsp_if.dst_y = ny_ff + fmrot_pkg::DST_W'(1);
      end else begin
         rsp_if.dst_x = nx_ff;
      end
   end

   assign rsp_if.valid      = mask_ff != '0;
   assign rsp_if.out_blue   = color_ff.blue;
   assign rsp_if.out_green  = color_ff.green;
   assign rsp_if.out_red    = color_ff.red;
   assign rsp_if.out_alpha  = color_ff.alpha;
   assign rsp_if.last_write = last;

   a_last_flag_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.last_write |-> $onehot(mask_ff))
      else $error("last write flagged with more taps pending");

   a_stall_holds_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> $stable(mask_ff))
      else $error("pending taps changed during stall");

   a_negative_dropped: assert property (@(posedge clock) disable iff (reset)
      load && neg |=> mask_ff == '0)
      else $error("negative target produced writes");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_if.last_write && !prod.valid |=> !rsp_if.valid)
      else $error("writes continued after last write");

endmodule

### rtl/forward_map_pixel_rotation_splat_top.sv
// forward-mapping pixel rotation with a five-point splat
//
// req_if   one source pixel per transaction: src_x, src_y and its color
// rsp_if   destination writes: dst_x, dst_y, color and last_write, which
//          marks the final write caused by a pixel
// csr_if   register writes by index (cos, sin, source center, destination
//          center, canvas width and height); always ready, write only
//          while no pixel is in flight
//
// a pixel gives zero to five writes, in order left, center, right, above,
// below; negative targets and writes off the canvas give nothing
// a request passes the input register, the product register and the
// emitter register, in that order, before its first write
// throughput: one write per cycle on rsp_if while rsp_if.ready is high;
// the next pixel loads when the last write of the one before is taken,
// and the single result channel limits this rate
// reset clears all valid state and restores register defaults
// a stalled receiver holds the current write; the two stages ahead keep
// filling, then req_if.ready drops
module forward_map_pixel_rotation_splat_top (
   input  logic        clock,
   input  logic        reset,
   fmrot_req_if.sink   req_if,
   fmrot_rsp_if.source rsp_if,
   fmrot_csr_if.sink   csr_if
);

   fmrot_pkg::cfg_type  cfg;
   fmrot_pkg::prod_type prod;
   logic                take;

   // configuration registers
   fmrot_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // center offsets and the four rotation products
   fmrot_xform u_xform (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .cfg    (cfg),
      .take   (take),
      .prod   (prod)
   );

   // sums, target, canvas checks and the write emitter
   fmrot_splat u_splat (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .prod   (prod),
      .take   (take),
      .rsp_if (rsp_if)
   );

endmodule
